[hdl/bsmt_pkg.sv]
// ----------------------------------------------------------------------------
// Backing-store map table package
// Item and result types, operation and status codes, and the command and
// status structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package bsmt_pkg;

  localparam int unsigned OpW      = 2;
  localparam int unsigned PidW     = 7;
  localparam int unsigned PageW    = 20;
  localparam int unsigned StoreW   = 3;
  localparam int unsigned CountW   = 9;
  localparam int unsigned StatusW  = 2;

  localparam logic [OpW-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OpW-1:0] OP_ADD    = 2'd1;
  localparam logic [OpW-1:0] OP_DROP   = 2'd2;

  localparam logic [StatusW-1:0] ST_OK   = 2'd0;
  localparam logic [StatusW-1:0] ST_BAD  = 2'd1;
  localparam logic [StatusW-1:0] ST_NONE = 2'd2;

  // Pages below this number belong to the kernel and are never mapped.
  localparam logic [PageW-1:0] LOW_PAGE_LIMIT = 20'd4096;

  typedef struct packed {
    logic [OpW-1:0]    operation;
    logic [PidW-1:0]   pid;
    logic [PageW-1:0]  virtual_page;
    logic [StoreW-1:0] store_index;
    logic [CountW-1:0] page_count;
  } item_t;

  // page_delta is the distance of the page from the base of the matching entry.
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [StoreW-1:0]  found_store;
    logic [CountW-1:0]  page_delta;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic               load;        // capture the input item
    logic               add_write;   // write the addressed entry
    logic               idx_clr;     // restart the entry scan
    logic               idx_inc;     // step to the next entry
    logic               rd_entry;    // read the scanned entry
    logic               drop_clear;  // invalidate the scanned entry
    logic               res_load;    // capture the result
    logic               res_hit;     // result carries store and offset
    logic [StatusW-1:0] res_status;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OpW-1:0] op;
    logic           args_bad;
    logic           hit;
    logic           last;
  } dp_sts_t;

endpackage

[hdl/bsmt_ctrl.sv]
// ----------------------------------------------------------------------------
// Backing-store map table controller
// Sequences one operation: argument check, add write or entry scan, result.
// ----------------------------------------------------------------------------
module bsmt_ctrl
  import bsmt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o,
  output logic    busy_o,
  output logic    done_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_READ     = 3'd2;
  localparam logic [2:0] S_CHECK    = 3'd3;
  localparam logic [2:0] S_RESP     = 3'd4;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts_i.args_bad) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_BAD;
          state_d          = S_RESP;
        end else if (sts_i.op == OP_ADD) begin
          cmd_o.add_write  = 1'b1;
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_OK;
          state_d          = S_RESP;
        end else begin
          cmd_o.idx_clr = 1'b1;
          state_d       = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd_entry = 1'b1;
        state_d        = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.op == OP_LOOKUP && sts_i.hit) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_hit    = 1'b1;
          cmd_o.res_status = ST_OK;
          state_d          = S_RESP;
        end else begin
          cmd_o.drop_clear = (sts_i.op == OP_DROP) && sts_i.hit;
          if (sts_i.last) begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = (sts_i.op == OP_LOOKUP) ? ST_NONE : ST_OK;
            state_d          = S_RESP;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_READ;
          end
        end
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_RESP);

endmodule

[hdl/bsmt_datapath.sv]
// ----------------------------------------------------------------------------
// Backing-store map table datapath
// Entry storage, argument check, scan index and the range compare.
// ----------------------------------------------------------------------------
module bsmt_datapath
  import bsmt_pkg::*;
#(
  parameter int unsigned NUM_STORES = 8,
  parameter int unsigned MAX_PAGES  = 256,
  parameter int unsigned NUM_PROCS  = 128
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  item_t   item_i,
  input  dp_cmd_t cmd_i,
  output dp_sts_t sts_o,
  output result_t result_o
);

  localparam int unsigned IdxW = (NUM_STORES > 1) ? $clog2(NUM_STORES) : 1;

  item_t item_q;

  logic [NUM_STORES-1:0] valid_q;
  logic [PidW-1:0]       owner_mem [NUM_STORES];
  logic [PageW-1:0]      base_mem  [NUM_STORES];
  logic [CountW-1:0]     pages_mem [NUM_STORES];

  logic [IdxW-1:0]   idx_q;
  logic              rd_valid_q;
  logic [PidW-1:0]   rd_owner_q;
  logic [PageW-1:0]  rd_base_q;
  logic [CountW-1:0] rd_pages_q;
  result_t           result_q;

  logic            pid_bad;
  logic            page_low;
  logic            add_bad;
  logic [IdxW-1:0] wr_idx;
  logic [PageW:0]  diff;
  logic            in_range;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
  end

  // Argument checks on the captured item.
  assign pid_bad  = (item_q.pid == '0) || ({1'b0, item_q.pid} >= (PidW+1)'(NUM_PROCS));
  assign page_low = (item_q.virtual_page < LOW_PAGE_LIMIT);
  assign add_bad  = page_low
                  || ((PidW)'(item_q.store_index) >= (PidW)'(NUM_STORES))
                  || (item_q.page_count > CountW'(MAX_PAGES));

  assign wr_idx = IdxW'(item_q.store_index);

  // Valid marks clear at reset; the payload of an invalid entry is never seen.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.add_write) begin
      valid_q[wr_idx] <= 1'b1;
    end else if (cmd_i.drop_clear) begin
      valid_q[idx_q] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_write) begin
      owner_mem[wr_idx] <= item_q.pid;
      base_mem[wr_idx]  <= item_q.virtual_page;
      pages_mem[wr_idx] <= item_q.page_count;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_entry) begin
      rd_valid_q <= valid_q[idx_q];
      rd_owner_q <= owner_mem[idx_q];
      rd_base_q  <= base_mem[idx_q];
      rd_pages_q <= pages_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.idx_clr) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  // Page lies in [base, base + pages) when the subtraction does not borrow
  // and the distance is below the count.
  assign diff     = {1'b0, item_q.virtual_page} - {1'b0, rd_base_q};
  assign in_range = !diff[PageW] && (diff[PageW-1:0] < PageW'(rd_pages_q));

  always_comb begin
    sts_o.op   = item_q.operation;
    sts_o.last = (idx_q == IdxW'(NUM_STORES - 1));
    sts_o.hit  = rd_valid_q && (rd_owner_q == item_q.pid)
               && ((item_q.operation == OP_DROP) || in_range);
    case (item_q.operation)
      OP_LOOKUP: sts_o.args_bad = pid_bad || page_low;
      OP_ADD:    sts_o.args_bad = pid_bad || add_bad;
      OP_DROP:   sts_o.args_bad = pid_bad;
      default:   sts_o.args_bad = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      result_q.status      <= cmd_i.res_status;
      result_q.found_store <= cmd_i.res_hit ? StoreW'(idx_q) : '0;
      result_q.page_delta  <= cmd_i.res_hit ? diff[CountW-1:0] : '0;
    end
  end

  assign result_o = result_q;

endmodule

[hdl/backing_store_map_table_unit.sv]
// ----------------------------------------------------------------------------
// Backing-store map table unit
// Maps ranges of virtual pages to backing stores, one entry per store, with
// lookup, add and drop-by-process operations.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake              Payload    Direction
//   -------   --------------------   --------   ---------
//   item      start / busy           item_i     in
//   result    done_o (one cycle)     result_o   out
//
// An item is taken at a rising edge where start is high and busy is low, and
// the unit then works on that item alone. Bad arguments and add go from the
// dispatch state straight to the result. Lookup and drop scan the entries in
// store order through a single registered read port, with a read state and a
// check state per entry; a lookup ends at its first match.
// The result is shown for one cycle with done_o high and busy drops in the
// following cycle. The receiver cannot stall. Reset clears every valid mark
// at once, so no clearing pass is needed.
module backing_store_map_table_unit
  import bsmt_pkg::*;
#(
  parameter int unsigned NUM_STORES = 8,
  parameter int unsigned MAX_PAGES  = 256,
  parameter int unsigned NUM_PROCS  = 128
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  item_t   item_i,
  output logic    busy,
  output logic    done_o,
  output result_t result_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // The controller sequences each operation; it sees only the status struct.
  bsmt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  // The datapath holds the table and evaluates one entry per scan step.
  bsmt_datapath #(
    .NUM_STORES (NUM_STORES),
    .MAX_PAGES  (MAX_PAGES),
    .NUM_PROCS  (NUM_PROCS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .result_o (result_o)
  );

endmodule

[hdl/bsmt_checker.sv]
// ----------------------------------------------------------------------------
// Backing-store map table checker
// Port-level properties of the unit, bound to every instance of the top.
// ----------------------------------------------------------------------------
module bsmt_checker
  import bsmt_pkg::*;
(
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start,
  input logic    busy,
  input logic    done_o,
  input result_t result_o
);

  // A result only appears while an item is in hand.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe without an item in hand");

  // An accepted item makes the unit busy, and no result follows at once.
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("accepted item did not start work");

  // After its result the unit is free again.
  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("unit stayed busy after its result");

  // Store and offset are zero on any result whose status is not OK.
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.status != ST_OK))
      |-> (result_o.found_store == '0 && result_o.page_delta == '0))
    else $error("store or offset set on a failed operation");

endmodule

bind backing_store_map_table_unit bsmt_checker u_bsmt_checker (.*);
